FILE: rtl/hs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap sort package
// Shared sizes and the stored record layout for the heap sort block.
// ----------------------------------------------------------------------------
package hs_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CHD_W  = IDX_W + 2;
   localparam int KEY_W  = 32;
   localparam int PROB_W = 64;
   localparam int FAC_W  = 16;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PROB_W-1:0]       prob;
      logic [FAC_W-1:0]        fac2;
      logic [FAC_W-1:0]        fac1;
      logic [FAC_W-1:0]        fac0;
   } rec_type;

   typedef struct packed {
      logic take;
      logic right;
   } pick_type;

endpackage
`default_nettype wire

FILE: rtl/heap_sort_with_payload.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap sort with payload
// Collects records, sorts them by signed key with an in-place heap sort and
// returns them in ascending key order.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Ports
// request   in         start & !busy       req_key, req_prob_bits, req_fac0..2,
//                                          req_last_in
// response  out        rsp_valid (strobe)  rsp_key_out, rsp_prob_out,
//                                          rsp_fac0..2_out, rsp_overflow,
//                                          rsp_last_out
//
// Loading accepts one item per cycle. The item marked last starts the sort.
// Each sift-down level does a dual read of both children, then a compare and
// one write, and each sift adds setup steps before its first level. The single
// record memory has two read ports and one write port.
// Results then stream out one per cycle. Reset is synchronous and clears the
// control state only. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module heap_sort_with_payload
   import hs_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [KEY_W-1:0] req_key,
   input  wire logic [PROB_W-1:0]       req_prob_bits,
   input  wire logic [FAC_W-1:0]        req_fac0,
   input  wire logic [FAC_W-1:0]        req_fac1,
   input  wire logic [FAC_W-1:0]        req_fac2,
   input  wire logic                    req_last_in,
   output logic                         rsp_valid,
   output logic signed [KEY_W-1:0]      rsp_key_out,
   output logic [PROB_W-1:0]            rsp_prob_out,
   output logic [FAC_W-1:0]             rsp_fac0_out,
   output logic [FAC_W-1:0]             rsp_fac1_out,
   output logic [FAC_W-1:0]             rsp_fac2_out,
   output logic                         rsp_overflow,
   output logic                         rsp_last_out
);

   typedef enum logic [3:0] {
      S_LOAD,
      S_FETCH,
      S_GRAB,
      S_READ,
      S_CMP,
      S_NEXT,
      S_XREAD,
      S_XSWAP,
      S_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             build_ff, build_in;
   logic             emit_v_ff, emit_v_in;
   logic             emit_last_ff, emit_last_in;
   logic             run_ovf_ff, run_ovf_in;
   rec_type          held_ff, held_in;

   rec_type          rec_mem [DEPTH];
   rec_type          rd_a_ff;
   rec_type          rd_b_ff;
   logic [IDX_W-1:0] ra, rb;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   rec_type          wr_data;

   logic             accept;
   logic             room;
   logic [CNT_W-1:0] cnt_after;
   logic [CNT_W-1:0] half;
   logic [CNT_W-1:0] i_m1;
   logic [CNT_W-1:0] i_m2;
   logic [CHD_W-1:0] lidx, ridx;
   logic             left_ok, right_ok;
   pick_type         pick;
   rec_type          req_rec;

   assign busy   = (state_ff != S_LOAD);
   assign accept = start && !busy;

   assign req_rec.key  = req_key;
   assign req_rec.prob = req_prob_bits;
   assign req_rec.fac0 = req_fac0;
   assign req_rec.fac1 = req_fac1;
   assign req_rec.fac2 = req_fac2;

   assign room      = (cnt_ff < CNT_W'(DEPTH));
   assign cnt_after = room ? (cnt_ff + CNT_W'(1)) : cnt_ff;
   assign half      = cnt_after >> 1;
   assign i_m1      = i_ff - CNT_W'(1);
   assign i_m2      = i_ff - CNT_W'(2);
   assign lidx      = {1'b0, pos_ff, 1'b1};
   assign ridx      = lidx + CHD_W'(1);
   assign left_ok   = (lidx < CHD_W'(len_ff));
   assign right_ok  = (ridx < CHD_W'(len_ff));

   hs_pick u_pick (
      .held_key  (held_ff.key),
      .left_key  (rd_a_ff.key),
      .right_key (rd_b_ff.key),
      .left_ok   (left_ok),
      .right_ok  (right_ok),
      .pick      (pick)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      build_in     = build_ff;
      emit_v_in    = 1'b0;
      emit_last_in = 1'b0;
      run_ovf_in   = run_ovf_ff;
      held_in      = held_ff;
      ra           = pos_ff;
      rb           = i_m1[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[IDX_W-1:0];
      wr_data      = req_rec;

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               wr_en  = room;
               cnt_in = cnt_after;
               ovf_in = ovf_ff || !room;
               if (req_last_in) begin
                  n_in       = cnt_after;
                  len_in     = cnt_after;
                  run_ovf_in = ovf_ff || !room;
                  cnt_in     = '0;
                  ovf_in     = 1'b0;
                  k_in       = '0;
                  if (cnt_after >= CNT_W'(2)) begin
                     build_in = 1'b1;
                     i_in     = half;
                     pos_in   = IDX_W'(half - CNT_W'(1));
                     state_in = S_FETCH;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_FETCH: begin
            ra       = pos_ff;
            state_in = S_GRAB;
         end
         S_GRAB: begin
            held_in  = rd_a_ff;
            state_in = S_READ;
         end
         S_READ: begin
            ra       = lidx[IDX_W-1:0];
            rb       = ridx[IDX_W-1:0];
            state_in = S_CMP;
         end
         S_CMP: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (pick.take) begin
               wr_data  = pick.right ? rd_b_ff : rd_a_ff;
               pos_in   = pick.right ? ridx[IDX_W-1:0] : lidx[IDX_W-1:0];
               state_in = S_READ;
            end else begin
               wr_data  = held_ff;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (build_ff) begin
               if (i_ff > CNT_W'(1)) begin
                  i_in     = i_m1;
                  pos_in   = i_m2[IDX_W-1:0];
                  state_in = S_FETCH;
               end else begin
                  build_in = 1'b0;
                  i_in     = n_ff;
                  state_in = S_XREAD;
               end
            end else if (i_ff > CNT_W'(2)) begin
               i_in     = i_m1;
               state_in = S_XREAD;
            end else begin
               k_in     = '0;
               state_in = S_EMIT;
            end
         end
         S_XREAD: begin
            ra       = '0;
            rb       = i_m1[IDX_W-1:0];
            state_in = S_XSWAP;
         end
         S_XSWAP: begin
            wr_en    = 1'b1;
            wr_addr  = i_m1[IDX_W-1:0];
            wr_data  = rd_a_ff;
            held_in  = rd_b_ff;
            pos_in   = '0;
            len_in   = i_m1;
            state_in = S_READ;
         end
         S_EMIT: begin
            ra           = k_ff[IDX_W-1:0];
            emit_v_in    = 1'b1;
            emit_last_in = ((k_ff + CNT_W'(1)) == n_ff);
            k_in         = k_ff + CNT_W'(1);
            if ((k_ff + CNT_W'(1)) == n_ff) begin
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         n_ff         <= '0;
         i_ff         <= '0;
         len_ff       <= '0;
         pos_ff       <= '0;
         k_ff         <= '0;
         build_ff     <= 1'b0;
         emit_v_ff    <= 1'b0;
         emit_last_ff <= 1'b0;
         run_ovf_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         build_ff     <= build_in;
         emit_v_ff    <= emit_v_in;
         emit_last_ff <= emit_last_in;
         run_ovf_ff   <= run_ovf_in;
      end
      held_ff <= held_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= rec_mem[ra];
      rd_b_ff <= rec_mem[rb];
   end

   assign rsp_valid    = emit_v_ff;
   assign rsp_key_out  = rd_a_ff.key;
   assign rsp_prob_out = rd_a_ff.prob;
   assign rsp_fac0_out = rd_a_ff.fac0;
   assign rsp_fac1_out = rd_a_ff.fac1;
   assign rsp_fac2_out = rd_a_ff.fac2;
   assign rsp_overflow = run_ovf_ff;
   assign rsp_last_out = emit_last_ff;

`ifndef NO_ASSERTIONS
   // A sorted run streams out without gaps until its last item.
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_out) |=> rsp_valid)
      else $error("sorted run broke before its last item");

   // Closing a set always starts the sort or the output run.
   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_in) |=> busy)
      else $error("closing item did not start the sort");

   // The sift position lies inside the current heap at every compare step.
   a_pos_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (CNT_W'(pos_ff) < len_ff))
      else $error("sift position outside the heap");
`endif

endmodule
`default_nettype wire

FILE: rtl/hs_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap sort child picker
// Shared compare unit for one sift-down level: decides whether the held record
// moves down, and toward which child. The left child is tested first.
// ----------------------------------------------------------------------------
module hs_pick
   import hs_pkg::*;
(
   input  wire logic signed [KEY_W-1:0] held_key,
   input  wire logic signed [KEY_W-1:0] left_key,
   input  wire logic signed [KEY_W-1:0] right_key,
   input  wire logic                    left_ok,
   input  wire logic                    right_ok,
   output pick_type                     pick
);

   logic                    left_win;
   logic signed [KEY_W-1:0] best_key;

   always_comb begin
      left_win   = left_ok && (left_key > held_key);
      best_key   = left_win ? left_key : held_key;
      pick.right = right_ok && (right_key > best_key);
      pick.take  = left_win || pick.right;
   end

endmodule
`default_nettype wire
